@@ hw/rtl/mbsp_pkg.sv @@
// shared types and constants of the midi byte stream parser
`timescale 1ns / 1ps

package mbsp_pkg;

   // event kinds
   localparam logic [4:0] KIND_PROGRAM       = 5'd4;
   localparam logic [4:0] KIND_CHAN_PRESSURE = 5'd5;
   localparam logic [4:0] KIND_SONG_POS      = 5'd7;
   localparam logic [4:0] KIND_SONG_SEL      = 5'd8;
   localparam logic [4:0] KIND_CLOCK         = 5'd9;
   localparam logic [4:0] KIND_START         = 5'd10;
   localparam logic [4:0] KIND_CONTINUE      = 5'd11;
   localparam logic [4:0] KIND_STOP          = 5'd12;
   localparam logic [4:0] KIND_TUNE          = 5'd13;
   localparam logic [4:0] KIND_ACTIVE_SENSE  = 5'd14;
   localparam logic [4:0] KIND_RESET         = 5'd15;
   localparam logic [4:0] KIND_SEGMENT       = 5'd16;
   localparam logic [4:0] KIND_ERROR         = 5'd17;

   // segment classes
   localparam logic [2:0] CLASS_OPEN      = 3'd0;
   localparam logic [2:0] CLASS_COMPLETE  = 3'd1;
   localparam logic [2:0] CLASS_FIRST     = 3'd2;
   localparam logic [2:0] CLASS_MIDDLE    = 3'd3;
   localparam logic [2:0] CLASS_LAST      = 3'd4;
   localparam logic [2:0] CLASS_CANCELLED = 3'd5;

   // status byte codes
   localparam logic [7:0] CODE_SYSEX_START  = 8'hF0;
   localparam logic [7:0] CODE_SONG_POS     = 8'hF2;
   localparam logic [7:0] CODE_SONG_SEL     = 8'hF3;
   localparam logic [7:0] CODE_SYSEX_CANCEL = 8'hF4;
   localparam logic [7:0] CODE_TUNE         = 8'hF6;
   localparam logic [7:0] CODE_SYSEX_END    = 8'hF7;
   localparam logic [7:0] CODE_CLOCK        = 8'hF8;
   localparam logic [7:0] CODE_START        = 8'hFA;
   localparam logic [7:0] CODE_CONTINUE     = 8'hFB;
   localparam logic [7:0] CODE_STOP         = 8'hFC;
   localparam logic [7:0] CODE_ACTIVE_SENSE = 8'hFE;
   localparam logic [7:0] CODE_RESET        = 8'hFF;

   typedef enum logic [3:0] {
      PHASE_IDLE    = 4'b0001,
      PHASE_FIRST   = 4'b0010,
      PHASE_SECOND  = 4'b0100,
      PHASE_SEGMENT = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [4:0] pending_kind;
      logic [3:0] pending_channel;
      logic [7:0] held_first_data;
      logic       opened_by_start_marker;
   } parse_state_type;

   typedef struct packed {
      logic [4:0] event_kind;
      logic [3:0] channel_number;
      logic [7:0] first_data;
      logic [7:0] second_data;
      logic [7:0] segment_value;
      logic       is_marker;
      logic       segment_end;
      logic [2:0] segment_class;
   } result_type;

endpackage

@@ hw/rtl/mbsp_decode.sv @@
// byte decoder: next parse state and result for one incoming byte
`timescale 1ns / 1ps

module mbsp_decode (
   input  mbsp_pkg::parse_state_type state_cur,
   input  logic [7:0]                midi_byte,
   output mbsp_pkg::parse_state_type state_nxt,
   output logic                      result_valid,
   output mbsp_pkg::result_type      result
);

   logic one_data;

   assign one_data = (state_cur.pending_kind == mbsp_pkg::KIND_PROGRAM)
                  || (state_cur.pending_kind == mbsp_pkg::KIND_CHAN_PRESSURE)
                  || (state_cur.pending_kind == mbsp_pkg::KIND_SONG_SEL);

   always_comb begin
      state_nxt    = state_cur;
      result_valid = 1'b0;
      result       = '0;
      case (state_cur.phase)
         mbsp_pkg::PHASE_FIRST: begin
            if (one_data) begin
               state_nxt.phase       = mbsp_pkg::PHASE_IDLE;
               result_valid          = 1'b1;
               result.event_kind     = state_cur.pending_kind;
               result.channel_number = state_cur.pending_channel;
               result.first_data     = midi_byte;
            end else begin
               state_nxt.held_first_data = midi_byte;
               state_nxt.phase           = mbsp_pkg::PHASE_SECOND;
            end
         end
         mbsp_pkg::PHASE_SECOND: begin
            state_nxt.phase       = mbsp_pkg::PHASE_IDLE;
            result_valid          = 1'b1;
            result.event_kind     = state_cur.pending_kind;
            result.channel_number = state_cur.pending_channel;
            result.first_data     = state_cur.held_first_data;
            result.second_data    = midi_byte;
         end
         mbsp_pkg::PHASE_SEGMENT: begin
            result_valid         = 1'b1;
            result.event_kind    = mbsp_pkg::KIND_SEGMENT;
            result.segment_value = midi_byte;
            if (midi_byte == mbsp_pkg::CODE_SYSEX_END
                  || midi_byte == mbsp_pkg::CODE_SYSEX_START
                  || midi_byte == mbsp_pkg::CODE_SYSEX_CANCEL) begin
               state_nxt.phase    = mbsp_pkg::PHASE_IDLE;
               result.is_marker   = 1'b1;
               result.segment_end = 1'b1;
               if (midi_byte == mbsp_pkg::CODE_SYSEX_CANCEL) begin
                  result.segment_class = mbsp_pkg::CLASS_CANCELLED;
               end else if (state_cur.opened_by_start_marker) begin
                  result.segment_class = (midi_byte == mbsp_pkg::CODE_SYSEX_END)
                                       ? mbsp_pkg::CLASS_COMPLETE
                                       : mbsp_pkg::CLASS_FIRST;
               end else begin
                  result.segment_class = (midi_byte == mbsp_pkg::CODE_SYSEX_START)
                                       ? mbsp_pkg::CLASS_MIDDLE
                                       : mbsp_pkg::CLASS_LAST;
               end
            end
         end
         mbsp_pkg::PHASE_IDLE: begin
            result_valid = 1'b1;
            case (midi_byte) inside
               [8'h00:8'h7F]: begin
                  result.event_kind = mbsp_pkg::KIND_ERROR;
               end
               [8'h80:8'hEF]: begin
                  result_valid              = 1'b0;
                  state_nxt.pending_kind    = {2'b00, midi_byte[6:4]};
                  state_nxt.pending_channel = midi_byte[3:0];
                  state_nxt.phase           = mbsp_pkg::PHASE_FIRST;
               end
               mbsp_pkg::CODE_SONG_POS, mbsp_pkg::CODE_SONG_SEL: begin
                  result_valid              = 1'b0;
                  state_nxt.pending_kind    = (midi_byte == mbsp_pkg::CODE_SONG_POS)
                                            ? mbsp_pkg::KIND_SONG_POS
                                            : mbsp_pkg::KIND_SONG_SEL;
                  state_nxt.pending_channel = 4'd0;
                  state_nxt.phase           = mbsp_pkg::PHASE_FIRST;
               end
               mbsp_pkg::CODE_SYSEX_START, mbsp_pkg::CODE_SYSEX_END: begin
                  state_nxt.opened_by_start_marker =
                     (midi_byte == mbsp_pkg::CODE_SYSEX_START);
                  state_nxt.phase      = mbsp_pkg::PHASE_SEGMENT;
                  result.event_kind    = mbsp_pkg::KIND_SEGMENT;
                  result.segment_value = midi_byte;
                  result.is_marker     = 1'b1;
               end
               mbsp_pkg::CODE_CLOCK:        result.event_kind = mbsp_pkg::KIND_CLOCK;
               mbsp_pkg::CODE_START:        result.event_kind = mbsp_pkg::KIND_START;
               mbsp_pkg::CODE_CONTINUE:     result.event_kind = mbsp_pkg::KIND_CONTINUE;
               mbsp_pkg::CODE_STOP:         result.event_kind = mbsp_pkg::KIND_STOP;
               mbsp_pkg::CODE_TUNE:         result.event_kind = mbsp_pkg::KIND_TUNE;
               mbsp_pkg::CODE_ACTIVE_SENSE: result.event_kind = mbsp_pkg::KIND_ACTIVE_SENSE;
               mbsp_pkg::CODE_RESET:        result.event_kind = mbsp_pkg::KIND_RESET;
               default:                     result.event_kind = mbsp_pkg::KIND_ERROR;
            endcase
         end
         default: begin
            state_nxt.phase = mbsp_pkg::PHASE_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/midi_byte_stream_parser_top.sv @@
// midi byte stream parser: one raw byte per transfer in, at most one event out
// Takes one MIDI byte per cycle while req_ready is high and registers the event that
// byte completes, if any. The decode of a byte is a single pass from the parse state
// register to the result register; the result side has an output register plus one
// skid entry, so bytes keep flowing while a result waits, and the input stalls only
// when both entries hold results. Sustained rate: one byte per clock.
`timescale 1ns / 1ps

module midi_byte_stream_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_midi_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_event_kind,
   output logic [3:0] rsp_channel_number,
   output logic [7:0] rsp_first_data,
   output logic [7:0] rsp_second_data,
   output logic [7:0] rsp_segment_value,
   output logic       rsp_is_marker,
   output logic       rsp_segment_end,
   output logic [2:0] rsp_segment_class
);

   mbsp_pkg::parse_state_type state_ff, state_in, state_dec;
   mbsp_pkg::result_type      out_ff, out_in, skid_ff, skid_in, dec_result;
   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic                      dec_valid;
   logic                      accept, push, pop;

   mbsp_decode u_decode (
      .state_cur    (state_ff),
      .midi_byte    (req_midi_byte),
      .state_nxt    (state_dec),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign push      = accept && dec_valid;
   assign pop       = out_valid_ff && rsp_ready;
   assign state_in  = accept ? state_dec : state_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = dec_result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = dec_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '{phase: mbsp_pkg::PHASE_IDLE, default: '0};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_ff.event_kind;
   assign rsp_channel_number = out_ff.channel_number;
   assign rsp_first_data     = out_ff.first_data;
   assign rsp_second_data    = out_ff.second_data;
   assign rsp_segment_value  = out_ff.segment_value;
   assign rsp_is_marker      = out_ff.is_marker;
   assign rsp_segment_end    = out_ff.segment_end;
   assign rsp_segment_class  = out_ff.segment_class;

   // skid entry is only filled behind a held output
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   // reset leaves the parser idle and the result side empty
   assert property (@(posedge clock)
      reset |=> (state_ff.phase == mbsp_pkg::PHASE_IDLE && !out_valid_ff && !skid_valid_ff))
      else $error("parser not idle after reset");

   // second data byte always completes an event and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == mbsp_pkg::PHASE_SECOND)
         |=> (state_ff.phase == mbsp_pkg::PHASE_IDLE && out_valid_ff))
      else $error("second data byte did not complete an event");

endmodule

@@ dv/midi_byte_stream_parser_top_tb.sv @@
// testbench for the midi byte stream parser: directed and random byte streams checked against a parse model
`timescale 1ns / 1ps

module midi_byte_stream_parser_top_tb;

   localparam logic [7:0] DATA_LAST            = 8'h7F;
   localparam logic [7:0] CHANNEL_STATUS_FIRST = 8'h80;
   localparam logic [7:0] CHANNEL_STATUS_LAST  = 8'hEF;
   localparam logic [7:0] CODE_UNDEFINED_F1    = 8'hF1;
   localparam logic [7:0] CODE_UNDEFINED_F5    = 8'hF5;
   localparam logic [7:0] CODE_UNDEFINED_F9    = 8'hF9;
   localparam logic [7:0] CODE_UNDEFINED_FD    = 8'hFD;
   localparam int         RANDOM_BYTES         = 900;
   localparam int         DRAIN_CYCLES         = 8;
   localparam int         CYCLE_LIMIT          = 500000;
   localparam int         MAX_REPORTS          = 10;

   localparam logic [7:0] ONE_BYTE_CODES [0:6] = '{
      mbsp_pkg::CODE_CLOCK, mbsp_pkg::CODE_START, mbsp_pkg::CODE_CONTINUE,
      mbsp_pkg::CODE_STOP, mbsp_pkg::CODE_TUNE, mbsp_pkg::CODE_ACTIVE_SENSE,
      mbsp_pkg::CODE_RESET
   };
   localparam logic [7:0] UNDEFINED_CODES [0:4] = '{
      CODE_UNDEFINED_F1, mbsp_pkg::CODE_SYSEX_CANCEL, CODE_UNDEFINED_F5,
      CODE_UNDEFINED_F9, CODE_UNDEFINED_FD
   };
   localparam logic [7:0] TERMINATOR_CODES [0:2] = '{
      mbsp_pkg::CODE_SYSEX_END, mbsp_pkg::CODE_SYSEX_START, mbsp_pkg::CODE_SYSEX_CANCEL
   };

   class midi_event_tracker;
      mbsp_pkg::phase_type  phase;
      logic [4:0]           pending_kind;
      logic [3:0]           pending_channel;
      logic [7:0]           held_first_data;
      logic                 opened_by_start;
      mbsp_pkg::result_type expected_events[$];
      int                   failures;

      function new();
         phase           = mbsp_pkg::PHASE_IDLE;
         pending_kind    = '0;
         pending_channel = '0;
         held_first_data = '0;
         opened_by_start = 1'b0;
         failures        = 0;
      endfunction

      function string describe(input mbsp_pkg::result_type r);
         return $sformatf("kind=%0d ch=%0d d1=%02h d2=%02h seg=%02h mark=%0b end=%0b cls=%0d",
            r.event_kind, r.channel_number, r.first_data, r.second_data,
            r.segment_value, r.is_marker, r.segment_end, r.segment_class);
      endfunction

      function void note_byte(input logic [7:0] b);
         mbsp_pkg::result_type ev;
         logic                 produced;
         ev       = '0;
         produced = 1'b0;
         case (phase)
            mbsp_pkg::PHASE_FIRST: begin
               if (pending_kind inside {mbsp_pkg::KIND_PROGRAM, mbsp_pkg::KIND_CHAN_PRESSURE,
                                        mbsp_pkg::KIND_SONG_SEL}) begin
                  ev.event_kind     = pending_kind;
                  ev.channel_number = pending_channel;
                  ev.first_data     = b;
                  produced          = 1'b1;
                  phase             = mbsp_pkg::PHASE_IDLE;
               end else begin
                  held_first_data = b;
                  phase           = mbsp_pkg::PHASE_SECOND;
               end
            end
            mbsp_pkg::PHASE_SECOND: begin
               ev.event_kind     = pending_kind;
               ev.channel_number = pending_channel;
               ev.first_data     = held_first_data;
               ev.second_data    = b;
               produced          = 1'b1;
               phase             = mbsp_pkg::PHASE_IDLE;
            end
            mbsp_pkg::PHASE_SEGMENT: begin
               ev.event_kind    = mbsp_pkg::KIND_SEGMENT;
               ev.segment_value = b;
               produced         = 1'b1;
               if (b inside {mbsp_pkg::CODE_SYSEX_END, mbsp_pkg::CODE_SYSEX_START,
                             mbsp_pkg::CODE_SYSEX_CANCEL}) begin
                  ev.is_marker   = 1'b1;
                  ev.segment_end = 1'b1;
                  if (b == mbsp_pkg::CODE_SYSEX_CANCEL)
                     ev.segment_class = mbsp_pkg::CLASS_CANCELLED;
                  else if (opened_by_start)
                     ev.segment_class = (b == mbsp_pkg::CODE_SYSEX_END)
                                        ? mbsp_pkg::CLASS_COMPLETE : mbsp_pkg::CLASS_FIRST;
                  else
                     ev.segment_class = (b == mbsp_pkg::CODE_SYSEX_START)
                                        ? mbsp_pkg::CLASS_MIDDLE : mbsp_pkg::CLASS_LAST;
                  phase = mbsp_pkg::PHASE_IDLE;
               end
            end
            default: begin
               produced = 1'b1;
               if (b <= DATA_LAST) begin
                  ev.event_kind = mbsp_pkg::KIND_ERROR;
               end else if (b <= CHANNEL_STATUS_LAST) begin
                  pending_kind    = {2'b00, b[6:4]};
                  pending_channel = b[3:0];
                  phase           = mbsp_pkg::PHASE_FIRST;
                  produced        = 1'b0;
               end else begin
                  case (b)
                     mbsp_pkg::CODE_SONG_POS, mbsp_pkg::CODE_SONG_SEL: begin
                        pending_kind    = (b == mbsp_pkg::CODE_SONG_POS)
                                          ? mbsp_pkg::KIND_SONG_POS : mbsp_pkg::KIND_SONG_SEL;
                        pending_channel = '0;
                        phase           = mbsp_pkg::PHASE_FIRST;
                        produced        = 1'b0;
                     end
                     mbsp_pkg::CODE_SYSEX_START, mbsp_pkg::CODE_SYSEX_END: begin
                        opened_by_start  = (b == mbsp_pkg::CODE_SYSEX_START);
                        phase            = mbsp_pkg::PHASE_SEGMENT;
                        ev.event_kind    = mbsp_pkg::KIND_SEGMENT;
                        ev.segment_value = b;
                        ev.is_marker     = 1'b1;
                     end
                     mbsp_pkg::CODE_CLOCK:    ev.event_kind = mbsp_pkg::KIND_CLOCK;
                     mbsp_pkg::CODE_START:    ev.event_kind = mbsp_pkg::KIND_START;
                     mbsp_pkg::CODE_CONTINUE: ev.event_kind = mbsp_pkg::KIND_CONTINUE;
                     mbsp_pkg::CODE_STOP:     ev.event_kind = mbsp_pkg::KIND_STOP;
                     mbsp_pkg::CODE_TUNE:     ev.event_kind = mbsp_pkg::KIND_TUNE;
                     mbsp_pkg::CODE_ACTIVE_SENSE:
                        ev.event_kind = mbsp_pkg::KIND_ACTIVE_SENSE;
                     mbsp_pkg::CODE_RESET:    ev.event_kind = mbsp_pkg::KIND_RESET;
                     default:                 ev.event_kind = mbsp_pkg::KIND_ERROR;
                  endcase
               end
            end
         endcase
         if (produced)
            expected_events.push_back(ev);
      endfunction

      function void check_event(input mbsp_pkg::result_type got);
         mbsp_pkg::result_type want;
         if (expected_events.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result at %0t: %s", $realtime, describe(got));
            return;
         end
         want = expected_events.pop_front();
         if (got.event_kind !== want.event_kind || got.channel_number !== want.channel_number ||
             got.first_data !== want.first_data || got.second_data !== want.second_data ||
             got.segment_value !== want.segment_value || got.is_marker !== want.is_marker ||
             got.segment_end !== want.segment_end ||
             got.segment_class !== want.segment_class) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("mismatch at %0t", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_midi_byte = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_event_kind;
   logic [3:0] rsp_channel_number;
   logic [7:0] rsp_first_data;
   logic [7:0] rsp_second_data;
   logic [7:0] rsp_segment_value;
   logic       rsp_is_marker;
   logic       rsp_segment_end;
   logic [2:0] rsp_segment_class;

   midi_event_tracker board = new();
   int bytes_sent     = 0;
   int req_calm_left  = 0;
   int rsp_calm_left  = 0;
   int rsp_stall_left = 0;
   int cycle_count    = 0;

   midi_byte_stream_parser_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_midi_byte      (req_midi_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_channel_number (rsp_channel_number),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_data    (rsp_second_data),
      .rsp_segment_value  (rsp_segment_value),
      .rsp_is_marker      (rsp_is_marker),
      .rsp_segment_end    (rsp_segment_end),
      .rsp_segment_class  (rsp_segment_class)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic logic [7:0] data_byte();
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom);
      return 8'($urandom_range(0, DATA_LAST));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(req_calm_left);
      if (gap > 0) begin
         req_valid     <= 1'b0;
         req_midi_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_midi_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_random_message();
      int         pick;
      int         count;
      logic [7:0] status;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         status = 8'($urandom_range(CHANNEL_STATUS_FIRST, CHANNEL_STATUS_LAST));
         count  = ({2'b00, status[6:4]} inside {mbsp_pkg::KIND_PROGRAM,
                                                mbsp_pkg::KIND_CHAN_PRESSURE}) ? 1 : 2;
         // truncated message now and then
         if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, count - 1);
         send_byte(status);
         repeat (count) send_byte(data_byte());
      end else if (pick < 50) begin
         if ($urandom_range(0, 1) == 1) begin
            send_byte(mbsp_pkg::CODE_SONG_POS);
            send_byte(data_byte());
            send_byte(data_byte());
         end else begin
            send_byte(mbsp_pkg::CODE_SONG_SEL);
            send_byte(data_byte());
         end
      end else if (pick < 65) begin
         send_byte(ONE_BYTE_CODES[$urandom_range(0, 6)]);
      end else if (pick < 85) begin
         send_byte($urandom_range(0, 1) == 1 ? mbsp_pkg::CODE_SYSEX_START
                                             : mbsp_pkg::CODE_SYSEX_END);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
         repeat (count) begin
            if ($urandom_range(0, 9) == 0)
               send_byte(8'($urandom_range(CHANNEL_STATUS_FIRST, 8'hFF)));
            else
               send_byte(8'($urandom_range(0, DATA_LAST)));
         end
         // unterminated segment now and then
         if ($urandom_range(0, 19) != 0)
            send_byte(TERMINATOR_CODES[$urandom_range(0, 2)]);
      end else if (pick < 93) begin
         send_byte(UNDEFINED_CODES[$urandom_range(0, 4)]);
      end else begin
         send_byte(8'($urandom_range(0, DATA_LAST)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_event({rsp_event_kind, rsp_channel_number, rsp_first_data,
                               rsp_second_data, rsp_segment_value, rsp_is_marker,
                               rsp_segment_end, rsp_segment_class});
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready      <= 1'b1;
            rsp_stall_left = pick_gap(rsp_calm_left);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] directed_bytes[$];
      directed_bytes = '{
         8'h00,
         CHANNEL_STATUS_FIRST, 8'h00, 8'hFF,
         8'hC5, 8'hFF,
         mbsp_pkg::CODE_SONG_POS, mbsp_pkg::CODE_SYSEX_START, DATA_LAST,
         mbsp_pkg::CODE_SYSEX_START, 8'h90, mbsp_pkg::CODE_SYSEX_END,
         mbsp_pkg::CODE_SYSEX_START, mbsp_pkg::CODE_SYSEX_START,
         mbsp_pkg::CODE_SYSEX_END, mbsp_pkg::CODE_SYSEX_START,
         mbsp_pkg::CODE_SYSEX_END, mbsp_pkg::CODE_SYSEX_END,
         mbsp_pkg::CODE_SYSEX_END, mbsp_pkg::CODE_SYSEX_CANCEL,
         CODE_UNDEFINED_F9, mbsp_pkg::CODE_START, mbsp_pkg::CODE_CONTINUE,
         mbsp_pkg::CODE_RESET
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      while (bytes_sent < directed_bytes.size() + RANDOM_BYTES)
         send_random_message();
      req_valid <= 1'b0;
      while (board.expected_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mbsp_pkg.sv
hw/rtl/mbsp_decode.sv
hw/rtl/midi_byte_stream_parser_top.sv
dv/midi_byte_stream_parser_top_tb.sv
